// ===== sv/ptsd_pkg.sv =====
// shared types, constants and helpers for the palette texture stream decoder
// no dependencies; imported by every module of the block
package ptsd_pkg;

   // stream parser modes
   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_PIXELS = 2'd2
   } mode_type;

   // header layout
   localparam logic [31:0] MAGIC_WORD    = 32'h3246_4950;
   localparam int          HDR_POS_W     = 11;
   localparam logic [10:0] HEADER_LAST   = 11'd1051;
   localparam logic [10:0] WIDTH_FIRST   = 11'd4;
   localparam logic [10:0] WIDTH_LAST    = 11'd7;
   localparam logic [10:0] HEIGHT_FIRST  = 11'd8;
   localparam logic [10:0] HEIGHT_LAST   = 11'd11;
   localparam logic [10:0] PALETTE_BASE  = 11'd28;

   // palette store geometry
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_ADDR_W  = $clog2(PAL_ENTRIES);

   // register and alpha constants
   localparam logic [15:0] MAX_DIM_RESET = 16'd1024;
   localparam logic [7:0]  ALPHA_HALF    = 8'h80;
   localparam logic [7:0]  ALPHA_FULL    = 8'hFF;

   // one byte write into the palette store
   typedef struct packed {
      logic                  en;
      logic [PAL_ADDR_W-1:0] entry;
      logic [1:0]            lane;
      logic [7:0]            data;
   } pal_wr_type;

   // one pixel lookup with its result tags
   typedef struct packed {
      logic                  valid;
      logic [PAL_ADDR_W-1:0] index;
      logic                  last;
      logic [15:0]           image_number;
      logic [31:0]           magic_offset;
   } pix_cmd_type;

   // pixel byte to palette index: bits 3 and 4 trade places
   function automatic logic [7:0] swap_bits_3_4(input logic [7:0] v);
      swap_bits_3_4 = {v[7:5], v[3], v[4], v[2:0]};
   endfunction

   // alpha expansion: half maps to full, anything else doubles and wraps
   function automatic logic [7:0] expand_alpha(input logic [7:0] a);
      expand_alpha = (a == ALPHA_HALF) ? ALPHA_FULL : {a[6:0], 1'b0};
   endfunction

endpackage

// ===== sv/ptsd_ctrl.sv =====
// stream parser: magic scan, header capture, pixel counting
// depends on ptsd_pkg; drives palette writes and pixel lookups
module ptsd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic [15:0]          max_dimension,
   output ptsd_pkg::pal_wr_type pal_wr,
   output ptsd_pkg::pix_cmd_type pix_cmd
);
   import ptsd_pkg::*;

   mode_type              mode_ff, mode_in;
   logic [1:0]            group_pos_ff, group_pos_in;
   logic [23:0]           group_bytes_ff, group_bytes_in;
   logic [HDR_POS_W-1:0]  header_pos_ff, header_pos_in;
   logic [31:0]           width_ff, width_in;
   logic [31:0]           height_ff, height_in;
   logic [31:0]           pixels_left_ff, pixels_left_in;
   logic [31:0]           area_ff, area_in;
   logic [15:0]           images_done_ff, images_done_in;
   logic [31:0]           stream_pos_ff, stream_pos_in;
   logic [31:0]           magic_off_ff, magic_off_in;

   logic                  magic_hit;
   logic                  header_end;
   logic                  dims_ok;
   logic                  last_pixel;
   logic [HDR_POS_W-1:0]  pal_rel;

   // shared decode terms
   assign magic_hit  = ({group_bytes_ff, data_byte} == MAGIC_WORD);
   assign header_end = (header_pos_ff == HEADER_LAST);
   assign dims_ok    = (width_ff[31:16] == 16'd0) && (height_ff[31:16] == 16'd0)
                       && (width_ff[15:0] <= max_dimension)
                       && (height_ff[15:0] <= max_dimension);
   assign last_pixel = (pixels_left_ff == 32'd1);
   assign pal_rel    = header_pos_ff - PALETTE_BASE;

   // pixel count, registered from the captured dimension bytes
   assign area_in = width_ff[15:0] * height_ff[15:0];

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (mode_ff)
            MODE_HEADER: begin
               if (header_end) begin
                  mode_in = (dims_ok && (area_ff != 32'd0)) ? MODE_PIXELS : MODE_SCAN;
               end
            end
            MODE_PIXELS: begin
               if (last_pixel) begin
                  mode_in = MODE_SCAN;
               end
            end
            default: begin
               mode_in = (group_pos_ff == 2'd3 && magic_hit) ? MODE_HEADER : MODE_SCAN;
            end
         endcase
      end
   end

   // next datapath state
   always_comb begin
      group_pos_in   = group_pos_ff;
      group_bytes_in = group_bytes_ff;
      header_pos_in  = header_pos_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      pixels_left_in = pixels_left_ff;
      images_done_in = images_done_ff;
      stream_pos_in  = stream_pos_ff;
      magic_off_in   = magic_off_ff;
      if (accept) begin
         stream_pos_in = stream_pos_ff + 32'd1;
         case (mode_ff)
            MODE_HEADER: begin
               if (header_pos_ff inside {[WIDTH_FIRST:WIDTH_LAST]}) begin
                  width_in[8*header_pos_ff[1:0] +: 8] = data_byte;
               end
               if (header_pos_ff inside {[HEIGHT_FIRST:HEIGHT_LAST]}) begin
                  height_in[8*header_pos_ff[1:0] +: 8] = data_byte;
               end
               if (header_end) begin
                  group_pos_in   = 2'd0;
                  group_bytes_in = 24'd0;
                  header_pos_in  = '0;
                  if (dims_ok) begin
                     pixels_left_in = area_ff;
                  end
               end else begin
                  header_pos_in = header_pos_ff + 11'd1;
               end
            end
            MODE_PIXELS: begin
               pixels_left_in = pixels_left_ff - 32'd1;
               if (last_pixel) begin
                  images_done_in = images_done_ff + 16'd1;
                  group_pos_in   = 2'd0;
                  group_bytes_in = 24'd0;
               end
            end
            default: begin
               if (group_pos_ff != 2'd3) begin
                  group_bytes_in = {group_bytes_ff[15:0], data_byte};
                  group_pos_in   = group_pos_ff + 2'd1;
               end else begin
                  group_pos_in   = 2'd0;
                  group_bytes_in = 24'd0;
                  if (magic_hit) begin
                     magic_off_in  = stream_pos_ff - 32'd3;
                     header_pos_in = '0;
                     width_in      = 32'd0;
                     height_in     = 32'd0;
                  end
               end
            end
         endcase
      end
   end

   // outputs: palette byte writes and pixel lookups
   always_comb begin
      pal_wr.en    = accept && (mode_ff == MODE_HEADER) && (header_pos_ff >= PALETTE_BASE);
      pal_wr.entry = pal_rel[9:2];
      pal_wr.lane  = pal_rel[1:0];
      pal_wr.data  = data_byte;

      pix_cmd.valid        = accept && (mode_ff == MODE_PIXELS);
      pix_cmd.index        = swap_bits_3_4(data_byte);
      pix_cmd.last         = last_pixel;
      pix_cmd.image_number = images_done_ff;
      pix_cmd.magic_offset = magic_off_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SCAN;
         group_pos_ff   <= 2'd0;
         group_bytes_ff <= 24'd0;
         header_pos_ff  <= '0;
         width_ff       <= 32'd0;
         height_ff      <= 32'd0;
         pixels_left_ff <= 32'd0;
         images_done_ff <= 16'd0;
         stream_pos_ff  <= 32'd0;
         magic_off_ff   <= 32'd0;
      end else begin
         mode_ff        <= mode_in;
         group_pos_ff   <= group_pos_in;
         group_bytes_ff <= group_bytes_in;
         header_pos_ff  <= header_pos_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         pixels_left_ff <= pixels_left_in;
         images_done_ff <= images_done_in;
         stream_pos_ff  <= stream_pos_in;
         magic_off_ff   <= magic_off_in;
      end
   end

   // product register, no reset needed
   always_ff @(posedge clock) begin
      area_ff <= area_in;
   end

endmodule

// ===== sv/ptsd_palette.sv =====
// 256 x 32 palette memory, byte-lane writes, registered read
// depends on ptsd_pkg for geometry and the write command type
module ptsd_palette (
   input  logic                                clock,
   input  ptsd_pkg::pal_wr_type                pal_wr,
   input  logic                                rd_en,
   input  logic [ptsd_pkg::PAL_ADDR_W-1:0]     rd_addr,
   output logic [31:0]                         rd_data
);
   import ptsd_pkg::*;

   logic [31:0] mem [PAL_ENTRIES];
   logic [31:0] rd_data_ff;

   // byte write from the header
   always_ff @(posedge clock) begin
      if (pal_wr.en) begin
         mem[pal_wr.entry][8*pal_wr.lane +: 8] <= pal_wr.data;
      end
   end

   // read, held until the next lookup
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ptsd_out.sv =====
// lookup stage and response register with alpha expansion
// depends on ptsd_pkg; takes the palette read data registered at the lookup
module ptsd_out (
   input  logic                  clock,
   input  logic                  reset,
   input  ptsd_pkg::pix_cmd_type pix_cmd,
   input  logic [31:0]           rd_data,
   output logic                  slot_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   output logic [7:0]            rsp_alpha,
   output logic                  rsp_last_of_image,
   output logic [15:0]           rsp_image_number,
   output logic [31:0]           rsp_magic_offset
);
   import ptsd_pkg::*;

   logic        look_valid_ff;
   logic        look_last_ff;
   logic [15:0] look_image_ff;
   logic [31:0] look_offset_ff;
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic        last_ff;
   logic [15:0] image_ff;
   logic [31:0] offset_ff;
   logic        advance;

   // the response register can take the lookup stage
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign slot_free = !look_valid_ff || advance;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         look_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (slot_free) begin
            look_valid_ff <= pix_cmd.valid;
         end
         if (advance) begin
            rsp_valid_ff <= look_valid_ff;
         end
      end
   end

   // lookup stage tags
   always_ff @(posedge clock) begin
      if (slot_free && pix_cmd.valid) begin
         look_last_ff   <= pix_cmd.last;
         look_image_ff  <= pix_cmd.image_number;
         look_offset_ff <= pix_cmd.magic_offset;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance && look_valid_ff) begin
         red_ff    <= rd_data[7:0];
         green_ff  <= rd_data[15:8];
         blue_ff   <= rd_data[23:16];
         alpha_ff  <= expand_alpha(rd_data[31:24]);
         last_ff   <= look_last_ff;
         image_ff  <= look_image_ff;
         offset_ff <= look_offset_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_alpha         = alpha_ff;
   assign rsp_last_of_image = last_ff;
   assign rsp_image_number  = image_ff;
   assign rsp_magic_offset  = offset_ff;

endmodule

// ===== sv/palette_texture_stream_decoder_top.sv =====
// top level of the palette texture stream decoder
// depends on ptsd_pkg, ptsd_ctrl, ptsd_palette and ptsd_out
//
//   channel   direction  ports                         moves
//   req_      in         req_data_byte                 one stream byte per request
//   rsp_      out        rsp_red .. rsp_magic_offset   one RGBA pixel per request
//   csr_      in         csr_max_dimension             max_dimension register
//
// One byte is accepted per cycle while req_ready is high; a pixel byte is read from
// the palette at the accepting edge and reaches rsp_ from the response register.
// Reset clears the parser and sets max_dimension to 1024; the palette is not cleared,
// every header rewrites it before pixels are read.
// A stalled rsp_ channel holds one pixel in the lookup stage and one in the
// response register; req_ready drops only when both are full.
module palette_texture_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_of_image,
   output logic [15:0] rsp_image_number,
   output logic [31:0] rsp_magic_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_dimension
);
   import ptsd_pkg::*;

   logic        accept;
   logic        slot_free;
   logic [15:0] max_dim_ff;
   logic [31:0] rd_data;
   pal_wr_type  pal_wr;
   pix_cmd_type pix_cmd;

   // request handshake
   assign req_ready = slot_free;
   assign accept    = req_valid && slot_free;
   assign csr_ready = 1'b1;

   // max_dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dim_ff <= MAX_DIM_RESET;
      end else if (csr_valid) begin
         max_dim_ff <= csr_max_dimension;
      end
   end

   ptsd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .max_dimension (max_dim_ff),
      .pal_wr        (pal_wr),
      .pix_cmd       (pix_cmd)
   );

   ptsd_palette u_palette (
      .clock   (clock),
      .pal_wr  (pal_wr),
      .rd_en   (pix_cmd.valid),
      .rd_addr (pix_cmd.index),
      .rd_data (rd_data)
   );

   ptsd_out u_out (
      .clock             (clock),
      .reset             (reset),
      .pix_cmd           (pix_cmd),
      .rd_data           (rd_data),
      .slot_free         (slot_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_of_image (rsp_last_of_image),
      .rsp_image_number  (rsp_image_number),
      .rsp_magic_offset  (rsp_magic_offset)
   );

endmodule

// ===== verif/palette_texture_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for palette_texture_stream_decoder_top
// depends on ptsd_pkg and the decoder rtl; feeds image streams and checks every pixel
// against a local decoder that runs on each accepted stream byte
module palette_texture_stream_decoder_top_tb;
   import ptsd_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 4;
   localparam int PLAN_ROWS     = 16;

   typedef enum int {PAL_RAMP, PAL_HALF_ALPHA, PAL_EXTREME, PAL_RANDOM} pal_fill_type;
   typedef enum int {PIX_RAMP, PIX_RANDOM, PIX_ONES, PIX_SWAP} pix_fill_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last_of_image;
      logic [15:0] image_number;
      logic [31:0] magic_offset;
   } pixel_type;

   // one directed image: optional max_dimension write, header fields, fills,
   // and the pixel count where it is obvious (-1 leaves it to the decoder)
   typedef struct {
      bit           set_limit;
      logic [15:0]  limit;
      logic [31:0]  width;
      logic [31:0]  height;
      pal_fill_type pal;
      pix_fill_type pix;
      bit           misalign;
      int           exp_pixels;
   } image_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_last_of_image;
   logic [15:0] rsp_image_number;
   logic [31:0] rsp_magic_offset;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_max_dimension;

   // local decoder state
   mode_type    parse_mode = MODE_SCAN;
   logic [1:0]  scan_phase = '0;
   logic [23:0] scan_shift = '0;
   logic [10:0] hdr_count = '0;
   logic [31:0] img_width = '0;
   logic [31:0] img_height = '0;
   logic [31:0] pixels_owed = '0;
   logic [31:0] palette_ram [PAL_ENTRIES];
   logic [15:0] image_count = '0;
   logic [31:0] byte_offset = '0;
   logic [31:0] magic_at = '0;
   logic [15:0] limit_dim = MAX_DIM_RESET;

   pixel_type pixel_queue [$];

   int failures = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int pixels_predicted = 0;
   int pixels_checked = 0;
   int headers_skipped = 0;
   int limit_writes = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   image_row_type image_plan [PLAN_ROWS] = '{
      // reset limit: smallest image, one past the limit, exactly at the limit
      '{1'b0, 16'd0, 32'd1, 32'd1, PAL_RAMP, PIX_RAMP, 1'b0, 1},
      '{1'b0, 16'd0, 32'd1025, 32'd1, PAL_RAMP, PIX_RAMP, 1'b0, 0},
      '{1'b0, 16'd0, 32'd1024, 32'd1, PAL_RAMP, PIX_RAMP, 1'b0, 1024},
      // zero width, then all-ones dimensions
      '{1'b0, 16'd0, 32'd0, 32'd5, PAL_RAMP, PIX_RAMP, 1'b0, 0},
      '{1'b0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PAL_RANDOM, PIX_RAMP, 1'b0, 0},
      // smallest limit, half alpha palette
      '{1'b1, 16'd1, 32'd1, 32'd1, PAL_HALF_ALPHA, PIX_SWAP, 1'b0, 1},
      '{1'b0, 16'd0, 32'd2, 32'd1, PAL_RANDOM, PIX_RANDOM, 1'b0, 0},
      '{1'b0, 16'd0, 32'd1, 32'd2, PAL_RANDOM, PIX_RANDOM, 1'b0, 0},
      // magic off the group boundary must not start an image
      '{1'b1, 16'd3, 32'd3, 32'd3, PAL_RANDOM, PIX_RANDOM, 1'b0, 9},
      '{1'b0, 16'd0, 32'd3, 32'd3, PAL_RANDOM, PIX_RANDOM, 1'b1, -1},
      '{1'b0, 16'd0, 32'd2, 32'd3, PAL_EXTREME, PIX_SWAP, 1'b0, 6},
      '{1'b1, 16'd8, 32'd8, 32'd2, PAL_EXTREME, PIX_ONES, 1'b0, 16},
      // largest limit: zero height, one past 16 bits, full width line
      '{1'b1, 16'hFFFF, 32'd65535, 32'd0, PAL_RAMP, PIX_RAMP, 1'b0, 0},
      '{1'b0, 16'd0, 32'd65536, 32'd1, PAL_RAMP, PIX_RAMP, 1'b0, 0},
      '{1'b0, 16'd0, 32'd65535, 32'd1, PAL_RAMP, PIX_RAMP, 1'b0, 65535},
      '{1'b0, 16'd0, 32'd5, 32'd7, PAL_RANDOM, PIX_RANDOM, 1'b0, -1}
   };

   palette_texture_stream_decoder_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_of_image (rsp_last_of_image),
      .rsp_image_number  (rsp_image_number),
      .rsp_magic_offset  (rsp_magic_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_dimension (csr_max_dimension)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // advance the local decoder by one accepted stream byte
   function automatic void decode_stream_byte(input logic [7:0] b);
      logic [7:0]  idx;
      logic [31:0] entry;
      logic [31:0] word;
      logic [10:0] rel;
      pixel_type   px;
      case (parse_mode)
         MODE_HEADER: begin
            if (hdr_count >= WIDTH_FIRST && hdr_count <= WIDTH_LAST)
               img_width[8*(hdr_count - WIDTH_FIRST) +: 8] = b;
            else if (hdr_count >= HEIGHT_FIRST && hdr_count <= HEIGHT_LAST)
               img_height[8*(hdr_count - HEIGHT_FIRST) +: 8] = b;
            else if (hdr_count >= PALETTE_BASE) begin
               rel = hdr_count - PALETTE_BASE;
               palette_ram[rel[9:2]][8*rel[1:0] +: 8] = b;
            end
            if (hdr_count == HEADER_LAST) begin
               parse_mode = MODE_SCAN;
               scan_phase = '0;
               scan_shift = '0;
               hdr_count = '0;
               pixels_owed = '0;
               if (img_width <= 32'(limit_dim) && img_height <= 32'(limit_dim))
                  pixels_owed = img_width * img_height;
               if (pixels_owed != 0)
                  parse_mode = MODE_PIXELS;
               else
                  headers_skipped++;
            end else begin
               hdr_count = hdr_count + 11'd1;
            end
         end
         MODE_PIXELS: begin
            // palette index is the byte with bits 3 and 4 exchanged
            idx = b;
            idx[3] = b[4];
            idx[4] = b[3];
            entry = palette_ram[idx];
            pixels_owed = pixels_owed - 32'd1;
            px.red = entry[7:0];
            px.green = entry[15:8];
            px.blue = entry[23:16];
            px.alpha = (entry[31:24] == ALPHA_HALF) ? ALPHA_FULL : 8'(entry[31:24] << 1);
            px.last_of_image = (pixels_owed == 0);
            px.image_number = image_count;
            px.magic_offset = magic_at;
            pixel_queue.push_back(px);
            pixels_predicted++;
            if (pixels_owed == 0) begin
               image_count = image_count + 16'd1;
               parse_mode = MODE_SCAN;
               scan_phase = '0;
               scan_shift = '0;
            end
         end
         default: begin
            parse_mode = MODE_SCAN;
            if (scan_phase != 2'd3) begin
               scan_shift = {scan_shift[15:0], b};
               scan_phase = scan_phase + 2'd1;
            end else begin
               word = {scan_shift, b};
               scan_phase = '0;
               scan_shift = '0;
               if (word == MAGIC_WORD) begin
                  magic_at = byte_offset - 32'd3;
                  parse_mode = MODE_HEADER;
                  hdr_count = '0;
                  img_width = '0;
                  img_height = '0;
               end
            end
         end
      endcase
      byte_offset = byte_offset + 32'd1;
   endfunction

   function automatic logic [7:0] palette_byte(input pal_fill_type kind, input int n);
      logic [7:0] entry;
      int lane;
      entry = 8'(n >> 2);
      lane = n & 3;
      case (kind)
         PAL_RAMP:
            palette_byte = (lane == 0) ? entry : (lane == 1) ? ~entry :
                           (lane == 2) ? (entry ^ 8'h5A) : entry;
         PAL_HALF_ALPHA: palette_byte = (lane == 3) ? ALPHA_HALF : 8'($urandom);
         PAL_EXTREME:    palette_byte = entry[0] ? 8'hFF : 8'h00;
         default:        palette_byte = 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pixel_byte(input pix_fill_type kind, input int k);
      case (kind)
         PIX_RAMP:   pixel_byte = 8'(k);
         PIX_ONES:   pixel_byte = 8'hFF;
         PIX_SWAP:   pixel_byte = (((k & 1) != 0) ? 8'h08 : 8'h10)
                                | (((k & 2) != 0) ? 8'h80 : 8'h00);
         default:    pixel_byte = 8'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         failures++;
      end
   endfunction

   // one stream byte request, with an optional idle burst in front
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_stream_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic push_magic(input int count);
      int k;
      for (k = 0; k < count; k++)
         push_byte(MAGIC_WORD[31 - 8*k -: 8]);
   endtask

   // finish any open header or image, then land on a group boundary
   task automatic align_to_group(input bit misalign);
      while (parse_mode != MODE_SCAN)
         push_byte(8'($urandom));
      while (scan_phase != 2'd0)
         push_byte(8'h00);
      if (misalign)
         push_byte(8'h00);
   endtask

   task automatic send_image(input logic [31:0] w, input logic [31:0] h,
                             input pal_fill_type pal, input pix_fill_type pix,
                             input bit misalign);
      int k;
      align_to_group(misalign);
      push_magic(4);
      for (k = 0; k < 4; k++) push_byte(8'($urandom));
      for (k = 0; k < 4; k++) push_byte(w[8*k +: 8]);
      for (k = 0; k < 4; k++) push_byte(h[8*k +: 8]);
      for (k = 12; k < PALETTE_BASE; k++) push_byte(8'($urandom));
      for (k = 0; k < 4*PAL_ENTRIES; k++) push_byte(palette_byte(pal, k));
      k = 0;
      while (parse_mode == MODE_PIXELS) begin
         push_byte(pixel_byte(pix, k));
         k++;
      end
   endtask

   // stop requests and let every expected pixel and the pipeline drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_max_dimension(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_max_dimension <= v;
      do @(posedge clock); while (!csr_ready);
      limit_dim = v;
      limit_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response stalls in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each delivered pixel with the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            $error("pixel with no expected value: red %0h green %0h blue %0h alpha %0h",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha);
            failures++;
         end else begin
            want = pixel_queue.pop_front();
            check_field("red", 32'(want.red), 32'(rsp_red));
            check_field("green", 32'(want.green), 32'(rsp_green));
            check_field("blue", 32'(want.blue), 32'(rsp_blue));
            check_field("alpha", 32'(want.alpha), 32'(rsp_alpha));
            check_field("last_of_image", 32'(want.last_of_image), 32'(rsp_last_of_image));
            check_field("image_number", 32'(want.image_number), 32'(rsp_image_number));
            check_field("magic_offset", want.magic_offset, rsp_magic_offset);
         end
         pixels_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("palette_texture_stream_decoder_top regression: fail");
         $finish;
      end
   end

   initial begin
      logic [15:0] phase_limit [RANDOM_PHASES];
      int          phase_goal [RANDOM_PHASES];
      logic [31:0] w;
      logic [31:0] h;
      logic [15:0] cap;
      int          seen_before;
      int          goal;
      int          pick;
      int          ph;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      csr_valid = 1'b0;
      csr_max_dimension = 16'h0000;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed images
      foreach (image_plan[r]) begin
         idle_pct = 25 * $urandom_range(0, 2);
         stall_pct = 25 * $urandom_range(0, 2);
         if (image_plan[r].set_limit) begin
            wait_idle();
            set_max_dimension(image_plan[r].limit);
         end
         if (image_plan[r].exp_pixels >= 0)
            wait_idle();
         seen_before = pixels_checked;
         send_image(image_plan[r].width, image_plan[r].height, image_plan[r].pal,
                    image_plan[r].pix, image_plan[r].misalign);
         if (image_plan[r].exp_pixels >= 0) begin
            wait_idle();
            if (pixels_checked - seen_before != image_plan[r].exp_pixels) begin
               $error("pixel count expected %0d got %0d", image_plan[r].exp_pixels,
                      pixels_checked - seen_before);
               failures++;
            end
         end
      end

      // random streams, one max_dimension setting per phase, last phase without idling or stalls
      phase_limit = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 40)), 16'd12};
      phase_goal = '{6, 180, 180, 180};
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         set_max_dimension(phase_limit[ph]);
         quiet = (ph == RANDOM_PHASES - 1);
         goal = pixels_predicted + phase_goal[ph];
         while (pixels_predicted < goal) begin
            idle_pct = 25 * $urandom_range(0, 2);
            stall_pct = 25 * $urandom_range(0, 2);
            cap = (limit_dim < 16'd8) ? limit_dim : 16'd8;
            w = $urandom_range(1, cap);
            h = $urandom_range(1, cap);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               // well-formed image, now and then exactly at the limit
               if (limit_dim <= 16'd40 && $urandom_range(0, 4) == 0)
                  w = 32'(limit_dim);
               send_image(w, h, pal_fill_type'($urandom_range(0, 3)),
                          pix_fill_type'($urandom_range(0, 3)), 1'b0);
            end else if (pick < 70) begin
               // oversized in one dimension
               if ($urandom_range(0, 1) == 0)
                  w = $urandom | 32'h0001_0000;
               else
                  w = 32'(limit_dim) + 32'd1;
               if ($urandom_range(0, 1) == 0)
                  send_image(w, h, PAL_RANDOM, PIX_RANDOM, 1'b0);
               else
                  send_image(h, w, PAL_RANDOM, PIX_RANDOM, 1'b0);
            end else if (pick < 78) begin
               // zero-size image
               h = $urandom_range(0, 65535);
               if ($urandom_range(0, 1) == 0)
                  send_image(32'd0, h, PAL_RANDOM, PIX_RANDOM, 1'b0);
               else
                  send_image(h, 32'd0, PAL_RANDOM, PIX_RANDOM, 1'b0);
            end else if (pick < 88) begin
               // noise, sometimes behind a partial magic
               if ($urandom_range(0, 1) == 0)
                  push_magic(3);
               repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
            end else if (pick < 94) begin
               // header cut short; whatever is sent next runs on inside it
               align_to_group(1'b0);
               push_magic(4);
               repeat ($urandom_range(0, 300)) push_byte(8'($urandom));
            end else begin
               send_image(w, h, PAL_RANDOM, PIX_RANDOM, 1'b1);
            end
         end
      end

      wait_idle();
      $display("covered %0d stream bytes, %0d pixels checked, %0d images decoded",
               bytes_sent, pixels_checked, image_count);
      $display("%0d headers skipped or empty, %0d max_dimension writes",
               headers_skipped, limit_writes);
      if (failures == 0)
         $display("palette_texture_stream_decoder_top regression: pass");
      else
         $display("palette_texture_stream_decoder_top regression: fail");
      $finish;
   end

endmodule
